### sv/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional list table: word formats,
// cell control, reduction tree nodes and derived widths.
// ----------------------------------------------------------------------------
package plc_pkg;

    // table size and derived widths
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    // reduction tree: groups of eight, enough levels to cover every cell
    localparam int GRP    = 8;
    localparam int LVL    = (IDX_W + 2) / 3;
    localparam int LEAVES = 1 << (3 * LVL);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;

    // request word
    typedef struct packed {
        logic [1:0]              func;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value_in;
    } plc_req_t;

    // response word
    typedef struct packed {
        logic                    ok;
        logic signed [DATA_W-1:0] value_out;
        logic [7:0]              found_position;
        logic [7:0]              list_length;
        logic                    is_empty;
    } plc_rsp_t;

    // broadcast control to every cell
    typedef struct packed {
        logic              advance;
        logic              ins;
        logic              del;
        logic              loc;
        logic [CMP_W-1:0]  pos_m1;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } plc_ctl_t;

    // one node of the hit reduction tree
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  tag;
        logic [DATA_W-1:0] data;
    } plc_node_t;

    // per-word status that travels beside the tree
    typedef struct packed {
        logic             valid;
        logic             loc;
        logic             ok;
        logic [CNT_W-1:0] count;
    } plc_side_t;

endpackage

### sv/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// One table slot: holds an entry, shifts from its left or right neighbor on
// insert or delete, and registers its hit flag for delete and locate.
// ----------------------------------------------------------------------------
module plc_cell (
    input  logic                          clk,
    input  logic [plc_pkg::IDX_W-1:0]     idx,
    input  plc_pkg::plc_ctl_t             ctl,
    input  logic [plc_pkg::DATA_W-1:0]    left,
    input  logic [plc_pkg::DATA_W-1:0]    right,
    output logic [plc_pkg::DATA_W-1:0]    entry,
    output plc_pkg::plc_node_t            node
);

    logic [plc_pkg::DATA_W-1:0] entry_reg;
    logic [plc_pkg::DATA_W-1:0] entry_next;
    logic                       entry_we;
    plc_pkg::plc_node_t         node_reg;
    plc_pkg::plc_node_t         node_next;
    logic [plc_pkg::CMP_W-1:0]  idx_c;
    logic [plc_pkg::CNT_W-1:0]  idx_n;
    logic                       at_pos;
    logic                       past_pos;
    logic                       sel;

    assign idx_c    = plc_pkg::CMP_W'(idx);
    assign idx_n    = plc_pkg::CNT_W'(idx);
    assign at_pos   = (idx_c == ctl.pos_m1);
    assign past_pos = (idx_c > ctl.pos_m1);

    // shift path
    always_comb
    begin
        entry_we   = 1'b0;
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (at_pos)
            begin
                entry_we   = 1'b1;
                entry_next = ctl.value;
            end
            else if (past_pos)
            begin
                entry_we   = 1'b1;
                entry_next = left;
            end
        end
        else if (ctl.del && (at_pos || past_pos))
        begin
            entry_we   = 1'b1;
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_reg <= entry_next;
        end
    end

    // hit flag, sampled before the shift takes effect
    assign sel = (ctl.del && at_pos) ||
                 (ctl.loc && (idx_n < ctl.count) && (entry_reg == ctl.value));

    always_comb
    begin
        node_next.hit  = sel;
        node_next.tag  = idx;
        node_next.data = (ctl.del && at_pos) ? entry_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            node_reg <= node_next;
        end
    end

    assign entry = entry_reg;
    assign node  = node_reg;

endmodule

### sv/plc_group.sv
// ----------------------------------------------------------------------------
// plc_group
// Registered reduction node: picks the lowest-index hit among eight inputs
// and merges their data (at most one carries a nonzero value).
// ----------------------------------------------------------------------------
module plc_group (
    input  logic                                 clk,
    input  logic                                 advance,
    input  plc_pkg::plc_node_t [plc_pkg::GRP-1:0] kids,
    output plc_pkg::plc_node_t                   node
);

    plc_pkg::plc_node_t node_reg;
    plc_pkg::plc_node_t node_next;

    // first hit wins, data is or-merged
    always_comb
    begin
        node_next = '0;
        for (int i = plc_pkg::GRP - 1; i >= 0; i--)
        begin
            if (kids[i].hit)
            begin
                node_next.tag = kids[i].tag;
            end
        end
        for (int i = 0; i < plc_pkg::GRP; i++)
        begin
            node_next.hit  = node_next.hit | kids[i].hit;
            node_next.data = node_next.data | kids[i].data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            node_reg <= node_next;
        end
    end

    assign node = node_reg;

endmodule

### sv/positional_list_table.sv
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered table of signed 32-bit entries with insert, delete and locate by
// 1-based position, built as a row of shifting cells and a hit tree.
// ----------------------------------------------------------------------------
// Pipeline: the cell hit registers, a registered node at each level of the
// eight-way hit tree, then the output register.
// Throughput: one word per cycle; the whole pipe holds while rsp_stall is
// high on a valid response, and req_stall follows that.
// Reset clears the length and the pipe valids; entries are not cleared.
// ----------------------------------------------------------------------------
module positional_list_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  plc_pkg::plc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output plc_pkg::plc_rsp_t rsp
);

    logic                        advance;
    logic                        accept;
    logic [plc_pkg::CNT_W-1:0]   count_reg;
    logic [plc_pkg::CNT_W-1:0]   count_next;
    logic [plc_pkg::CMP_W:0]     pos_x;
    logic [plc_pkg::CMP_W:0]     cnt_x;
    logic                        ins_ok;
    logic                        del_ok;
    plc_pkg::plc_ctl_t           ctl;
    plc_pkg::plc_side_t          side_reg [0:plc_pkg::LVL];
    plc_pkg::plc_side_t          side_next;
    logic                        rsp_valid_reg;
    plc_pkg::plc_rsp_t           rsp_reg;
    plc_pkg::plc_rsp_t           rsp_next;
    logic [plc_pkg::DATA_W-1:0]  entry [plc_pkg::CAPACITY];
    plc_pkg::plc_node_t [plc_pkg::LEAVES-1:0] lvl [0:plc_pkg::LVL];

    // pipe moves unless a response is held
    assign advance   = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !advance;
    assign accept    = req_valid && advance;

    // range checks
    assign pos_x  = (plc_pkg::CMP_W + 1)'(req.position);
    assign cnt_x  = (plc_pkg::CMP_W + 1)'(count_reg);
    assign ins_ok = (req.func == plc_pkg::OP_INSERT) && (req.position != '0) &&
                    (pos_x <= cnt_x + 1'b1) &&
                    (count_reg < plc_pkg::CNT_W'(plc_pkg::CAPACITY));
    assign del_ok = (req.func == plc_pkg::OP_DELETE) && (req.position != '0) &&
                    (pos_x <= cnt_x);

    // length update
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (del_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // broadcast control
    always_comb
    begin
        ctl.advance = advance;
        ctl.ins     = accept && ins_ok;
        ctl.del     = accept && del_ok;
        ctl.loc     = accept && (req.func == plc_pkg::OP_LOCATE);
        ctl.pos_m1  = plc_pkg::CMP_W'(req.position) - 1'b1;
        ctl.count   = count_reg;
        ctl.value   = req.value_in;
    end

    // row of cells, padded out to a full tree
    for (genvar i = 0; i < plc_pkg::LEAVES; i++)
    begin : g_cell
        if (i < plc_pkg::CAPACITY)
        begin : g_live
            logic [plc_pkg::DATA_W-1:0] left_w;
            logic [plc_pkg::DATA_W-1:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = entry[i-1];
            end
            if (i == plc_pkg::CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = entry[i+1];
            end
            plc_cell u_cell (
                .clk   (clk),
                .idx   (plc_pkg::IDX_W'(i)),
                .ctl   (ctl),
                .left  (left_w),
                .right (right_w),
                .entry (entry[i]),
                .node  (lvl[0][i])
            );
        end
        else
        begin : g_pad
            assign lvl[0][i] = '0;
        end
    end

    // hit tree, eight to one per level
    for (genvar l = 1; l <= plc_pkg::LVL; l++)
    begin : g_lvl
        for (genvar j = 0; j < plc_pkg::LEAVES; j++)
        begin : g_node
            if (j < (plc_pkg::LEAVES >> (3 * l)))
            begin : g_live
                plc_group u_group (
                    .clk     (clk),
                    .advance (advance),
                    .kids    (lvl[l-1][plc_pkg::GRP*j +: plc_pkg::GRP]),
                    .node    (lvl[l][j])
                );
            end
            else
            begin : g_pad
                assign lvl[l][j] = '0;
            end
        end
    end

    // status pipe beside the tree
    always_comb
    begin
        side_next.valid = accept;
        side_next.loc   = req.func == plc_pkg::OP_LOCATE;
        side_next.ok    = ins_ok || del_ok;
        side_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= plc_pkg::LVL; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= plc_pkg::LVL; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // response assembly
    always_comb
    begin
        rsp_next.ok        = side_reg[plc_pkg::LVL].ok ||
                             (side_reg[plc_pkg::LVL].loc && lvl[plc_pkg::LVL][0].hit);
        rsp_next.value_out = lvl[plc_pkg::LVL][0].data;
        rsp_next.found_position = '0;
        if (side_reg[plc_pkg::LVL].loc && lvl[plc_pkg::LVL][0].hit)
        begin
            rsp_next.found_position =
                8'(plc_pkg::CNT_W'(lvl[plc_pkg::LVL][0].tag) + 1'b1);
        end
        rsp_next.list_length = 8'(side_reg[plc_pkg::LVL].count);
        rsp_next.is_empty    = side_reg[plc_pkg::LVL].count == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= side_reg[plc_pkg::LVL].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the positional list table, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input plc_pkg::plc_rsp_t rsp
);

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // empty flag agrees with the length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.list_length == 8'd0)))
        else $error("is_empty disagrees with list_length");

    // a found position only comes with success and no removed value
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.found_position != 8'd0) |->
            rsp.ok && (rsp.value_out == '0))
        else $error("found position without a clean locate result");

    // a removed value only comes from a successful delete
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.value_out != '0) |->
            rsp.ok && (rsp.found_position == 8'd0))
        else $error("removed value without a clean delete result");

    // length never passes the table size
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.list_length <= 8'(plc_pkg::CAPACITY)))
        else $error("list length beyond capacity");

endmodule

bind positional_list_table plc_checker u_plc_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list table: directed corner words
// then fill and drain sequences with random content, checked against an
// in-bench model of the ordered table under random idling and a long hold.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int PIPE_LAT   = 5;
    localparam int DRAIN_WAIT = 4 * PIPE_LAT;
    localparam int RAND_OPS   = 1280;
    localparam int PHASE_A    = 430;
    localparam int PHASE_B    = 860;
    localparam int HOLD_AT    = 1000;
    localparam int HOLD_LEN   = 150;
    localparam int STALL_MAX  = 4000;
    localparam int MAX_REPORT = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    plc_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    plc_rsp_t rsp;

    positional_list_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // words waiting to be driven and results the table owes us
    plc_req_t pending_ops[$];
    plc_rsp_t due_results[$];

    // model of the table contents
    logic signed [DATA_W-1:0] model_entries[CAPACITY];
    int model_len = 0;

    // length seen by the word generator
    int gen_len = 0;

    int  total_ops      = 0;
    int  accepted_items = 0;
    int  checked_items  = 0;
    int  fail_count     = 0;
    int  stall_cycles   = 0;
    int  hold_cycles    = 0;
    int  n_ins_ok       = 0;
    int  n_del_ok       = 0;
    int  n_loc_hit      = 0;
    int  n_rejected     = 0;
    int  n_full_reject  = 0;
    int  peak_len       = 0;
    logic req_accepted  = 1'b0;

    // apply one word to the model and return the result it should produce
    function automatic plc_rsp_t apply_list_op(input plc_req_t w);
        plc_rsp_t r;
        int       p;
        r = '0;
        p = int'(w.position);
        case (w.func)
            OP_INSERT:
            begin
                if (p >= 1 && p <= model_len + 1 && model_len < CAPACITY)
                begin
                    for (int j = model_len; j >= p; j--)
                        model_entries[j] = model_entries[j-1];
                    model_entries[p-1] = w.value_in;
                    model_len++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (p >= 1 && p <= model_len)
                begin
                    r.value_out = model_entries[p-1];
                    for (int j = p; j < model_len; j++)
                        model_entries[j-1] = model_entries[j];
                    model_len--;
                    r.ok = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                for (int j = 0; j < model_len; j++)
                begin
                    if (!r.ok && model_entries[j] == w.value_in)
                    begin
                        r.found_position = 8'(j + 1);
                        r.ok             = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.list_length = 8'(model_len);
        r.is_empty    = (model_len == 0);
        return r;
    endfunction

    // queue one word and track the length it leaves behind
    task automatic push_op(input logic [1:0] f, input int p, input int v);
        plc_req_t w;
        w.func     = f;
        w.position = p[POS_W-1:0];
        w.value_in = v;
        if (f == OP_INSERT && w.position >= 1 && w.position <= gen_len + 1
            && gen_len < CAPACITY)
            gen_len++;
        else if (f == OP_DELETE && w.position >= 1 && w.position <= gen_len)
            gen_len--;
        pending_ops.push_back(w);
        total_ops++;
    endtask

    // value mix: small values for repeats and hits, extremes, full range
    function automatic int pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return $urandom_range(15) - 8;
        else if (roll < 60)
            return 32'h8000_0000;
        else if (roll < 70)
            return 32'h7fff_ffff;
        else
            return $urandom;
    endfunction

    // idle percentage for each side in the current phase
    function automatic int idle_pct(input bit sender);
        if (accepted_items < PHASE_A)
            return sender ? 35 : 76;
        else if (accepted_items < PHASE_B)
            return sender ? 76 : 35;
        else
            return 0;
    endfunction

    // driver: next word goes out once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_accepted)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct(1'b1))
            begin
                req       <= pending_ops.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver: random stall plus one long hold to back the pipe up
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (accepted_items >= HOLD_AT && hold_cycles < HOLD_LEN)
        begin
            hold_cycles++;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge clk)
    begin
        plc_rsp_t want;
        if (rst_n)
        begin
            req_accepted <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                if (req.func == OP_INSERT && model_len == CAPACITY)
                    n_full_reject++;
                want = apply_list_op(req);
                due_results.push_back(want);
                accepted_items++;
                if (want.ok && req.func == OP_INSERT)
                    n_ins_ok++;
                else if (want.ok && req.func == OP_DELETE)
                    n_del_ok++;
                else if (want.ok && req.func == OP_LOCATE)
                    n_loc_hit++;
                else
                    n_rejected++;
                if (model_len > peak_len)
                    peak_len = model_len;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("unexpected result word at %0t", $time);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.ok !== want.ok || rsp.value_out !== want.value_out
                        || rsp.found_position !== want.found_position
                        || rsp.list_length !== want.list_length
                        || rsp.is_empty !== want.is_empty)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT)
                        begin
                            $display("mismatch on result %0d: exp ok=%0b val=%0d pos=%0d",
                                     checked_items, want.ok, want.value_out,
                                     want.found_position);
                            $display("  exp len=%0d empty=%0b", want.list_length,
                                     want.is_empty);
                            $display("  got ok=%0b val=%0d pos=%0d len=%0d empty=%0b",
                                     rsp.ok, rsp.value_out, rsp.found_position,
                                     rsp.list_length, rsp.is_empty);
                        end
                    end
                end
                checked_items++;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no progress for %0d cycles", STALL_MAX);
                $display("positional_list_table verification failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        bit fill_mode;
        int full_hits;
        int roll;

        // directed corners
        push_op(OP_LOCATE, 0, 0);              // locate on empty table
        push_op(OP_DELETE, 1, 0);              // delete on empty table
        push_op(OP_INSERT, 0, 7);              // position zero
        push_op(OP_INSERT, 2, 7);              // past the end
        push_op(OP_INSERT, 1, 32'h8000_0000);
        push_op(OP_INSERT, 2, 32'h7fff_ffff);  // append at end
        push_op(OP_INSERT, 1, -1);             // at the front
        push_op(OP_INSERT, 2, 0);              // in the middle
        push_op(OP_INSERT, 255, 3);            // every position bit set
        push_op(OP_LOCATE, 0, 32'h7fff_ffff);
        push_op(OP_LOCATE, 77, 32'h8000_0000);
        push_op(OP_LOCATE, 0, 12345);          // no match
        push_op(OP_INSERT, 3, -1);             // duplicate value
        push_op(OP_LOCATE, 0, -1);             // first of two matches
        push_op(2'd3, 1, 5);                   // unused code
        push_op(2'd3, 255, -1);
        push_op(OP_DELETE, 0, 0);              // position zero
        push_op(OP_DELETE, 6, 0);              // past the end
        push_op(OP_DELETE, 5, 9);              // last entry
        push_op(OP_DELETE, 1, 0);              // first entry
        push_op(OP_DELETE, 2, 0);              // middle entry
        push_op(OP_LOCATE, 0, 32'h8000_0000);
        push_op(OP_DELETE, 1, 0);
        push_op(OP_DELETE, 1, 0);              // back to empty
        push_op(OP_DELETE, 255, -1);

        // fill and drain sequences with some noise mixed in
        fill_mode = 1'b1;
        full_hits = 0;
        repeat (RAND_OPS)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
                push_op(2'($urandom_range(3)), $urandom_range(255), $urandom);
            else if (roll < 22)
                push_op(OP_LOCATE, $urandom_range(255), pick_value());
            else if ((roll < 78) == fill_mode)
                push_op(OP_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
            else if (gen_len > 0)
                push_op(OP_DELETE, $urandom_range(gen_len, 1), $urandom);
            else
                push_op(OP_DELETE, $urandom_range(3), $urandom);

            // turn around at the ends after lingering a little at full
            if (fill_mode && gen_len == CAPACITY)
                full_hits++;
            if (fill_mode && full_hits >= 8)
            begin
                fill_mode = 1'b0;
                full_hits = 0;
            end
            else if (!fill_mode && gen_len == 0)
                fill_mode = 1'b1;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_items == total_ops && due_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d words: %0d inserts, %0d deletes, %0d locate hits, %0d rejected",
                 accepted_items, n_ins_ok, n_del_ok, n_loc_hit, n_rejected);
        $display("peak length %0d, %0d inserts refused on a full table, %0d mismatches",
                 peak_len, n_full_reject, fail_count);
        if (fail_count == 0 && due_results.size() == 0)
            $display("positional_list_table verification clean");
        else
            $display("positional_list_table verification failed");
        $finish;
    end

endmodule

### files.f
sv/plc_pkg.sv
sv/plc_cell.sv
sv/plc_group.sv
sv/positional_list_table.sv
sv/plc_checker.sv
tb/tb.sv
